/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL of the name transcoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/u2l_pkg.sv */
// Package: types, constants and sizes of the UTF-8 to Latin-1 name transcoder.
`default_nettype none
package u2l_pkg;

  localparam int MAX_CHARS     = 15;
  localparam int PAYLOAD_BYTES = 16;
  localparam int OUT_LIMIT     = 16;
  localparam int OUT_COUNT     = (PAYLOAD_BYTES < OUT_LIMIT) ? PAYLOAD_BYTES : OUT_LIMIT;
  localparam int MEM_DEPTH     = OUT_COUNT;
  localparam int IDX_W         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LEN_W         = 5;
  localparam int SUM_W         = 6;

  localparam logic [4:0] PEND_MAX  = 5'd31;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] ASCII_TOP = 8'h7F;
  localparam logic [7:0] LEAD2_MSK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG = 8'hC0;
  localparam logic [7:0] LEAD3_MSK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG = 8'hE0;
  localparam logic [7:0] LEAD4_MSK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG = 8'hF0;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_INVALID     = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_t;

  // Decoder state carried between bytes of one name
  typedef struct packed {
    logic [LEN_W-1:0] committed;
    logic [4:0]       pending;
    logic             seen;
    logic             lead;
    logic [4:0]       lead_bits;
    status_t          err;
  } dec_state_t;

  // Payload memory write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

endpackage
`default_nettype wire

/* rtl/core/u2l_in_if.sv */
// Input channel: at most one UTF-8 byte per transfer, flagged by byte_present.
`default_nettype none
interface u2l_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_present;
  logic       is_last;

  modport source (output valid, output in_byte, output byte_present, output is_last,
                  input ready);
  modport sink (input valid, input in_byte, input byte_present, input is_last,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/u2l_out_if.sv */
// Result channel: one Latin-1 payload byte per transfer.
`default_nettype none
interface u2l_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [3:0] byte_index;
  logic [2:0] status;
  logic       last_out;

  modport source (output valid, output payload_byte, output byte_index, output status,
                  output last_out, input ready);
  modport sink (input valid, input payload_byte, input byte_index, input status,
                input last_out, output ready);
endinterface
`default_nettype wire

/* rtl/core/u2l_step.sv */
// Per-byte decoder: whitespace handling, two-byte decode and length checks.
`default_nettype none
module u2l_step import u2l_pkg::*; (
  input  dec_state_t cur,
  input  logic [7:0] in_byte,
  input  logic       byte_present,
  output dec_state_t nxt,
  output mem_wr_t    wr,
  output status_t    end_status
);

  logic [SUM_W-1:0] sum;
  logic [10:0]      cp;
  logic             is_ws;
  logic             pos_ok;

  always_comb begin
    nxt     = cur;
    wr      = '0;
    sum     = SUM_W'(cur.committed) + SUM_W'(cur.pending);
    cp      = {cur.lead_bits, in_byte[5:0]};
    is_ws   = (in_byte == 8'h20) || ((in_byte >= 8'h09) && (in_byte <= 8'h0D));
    pos_ok  = (sum < SUM_W'(MEM_DEPTH));
    wr.addr = sum[IDX_W-1:0];
    wr.data = in_byte;

    // Decode one byte unless an error already stands
    if (byte_present && (cur.err == ST_OK)) begin
      priority if (cur.lead) begin
        // Continuation byte of a two-byte sequence
        nxt.lead = 1'b0;
        priority if ((in_byte & CONT_MASK) != CONT_TAG) begin
          nxt.err = ST_INVALID;
        end else if (cp < 11'h080) begin
          nxt.err = ST_INVALID;
        end else if (cp > 11'h0FF) begin
          nxt.err = ST_UNSUPPORTED;
        end else if (cur.committed >= LEN_W'(MAX_CHARS)) begin
          nxt.err = ST_TOO_LONG;
        end else begin
          wr.en         = pos_ok;
          wr.data       = cp[7:0];
          nxt.committed = LEN_W'(cur.committed + 1'b1);
        end
      end else if (is_ws) begin
        // Hold trailing whitespace tentatively; drop it before content
        if (cur.seen) begin
          wr.en = pos_ok;
          if (cur.pending != PEND_MAX) begin
            nxt.pending = cur.pending + 5'd1;
          end
        end
      end else begin
        // Content: commit pending whitespace, then take the byte
        nxt.seen = 1'b1;
        if (sum > SUM_W'(MAX_CHARS)) begin
          nxt.err = ST_TOO_LONG;
        end else begin
          nxt.committed = sum[LEN_W-1:0];
          nxt.pending   = '0;
          priority if (in_byte <= ASCII_TOP) begin
            if (sum >= SUM_W'(MAX_CHARS)) begin
              nxt.err = ST_TOO_LONG;
            end else begin
              wr.en         = pos_ok;
              nxt.committed = LEN_W'(sum + 1'b1);
            end
          end else if ((in_byte & LEAD2_MSK) == LEAD2_TAG) begin
            nxt.lead      = 1'b1;
            nxt.lead_bits = in_byte[4:0];
          end else if (((in_byte & LEAD3_MSK) == LEAD3_TAG) ||
                       ((in_byte & LEAD4_MSK) == LEAD4_TAG)) begin
            nxt.err = ST_UNSUPPORTED;
          end else begin
            nxt.err = ST_INVALID;
          end
        end
      end
    end

    // Status of the name if it ends with this item
    priority if (nxt.err != ST_OK) begin
      end_status = nxt.err;
    end else if (!nxt.seen) begin
      end_status = ST_EMPTY;
    end else if (nxt.lead) begin
      end_status = ST_INVALID;
    end else begin
      end_status = ST_OK;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/utf8_to_latin1_name_encoder_top.sv */
// Top level: UTF-8 name to zero-padded Latin-1 payload with status.
//
//   channel | dir | fields                                       | transfer
//   in_ch   | in  | in_byte, byte_present, is_last               | valid && ready
//   out_ch  | out | payload_byte, byte_index, status, last_out   | valid && ready
//
// Input bytes are taken one per cycle while the name is being collected.
// After the last item, the S_READ state does the first payload memory read, then
// OUT_COUNT results follow at up to one per cycle, paced by the single read port.
// Input ready is low while the payload is sent; a stalled result holds.
// Reset clears the control state; the payload memory needs no clearing.
`default_nettype none
`include "assert_macros.svh"
module utf8_to_latin1_name_encoder_top import u2l_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  u2l_in_if.sink    in_ch,
  u2l_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_COLLECT = 3'b001,
    S_READ    = 3'b010,
    S_SEND    = 3'b100
  } fsm_t;

  fsm_t             state_r, state_nxt;
  dec_state_t       dec_r, dec_nxt;
  dec_state_t       step_nxt;
  mem_wr_t          step_wr;
  status_t          step_status;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       payload_mem_r [MEM_DEPTH];
  logic [7:0]       rd_data_r;
  logic             in_xfer;
  logic             out_xfer;
  logic             at_last;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             in_len;

  u2l_step u_step (
    .cur          (dec_r),
    .in_byte      (in_ch.in_byte),
    .byte_present (in_ch.byte_present),
    .nxt          (step_nxt),
    .wr           (step_wr),
    .end_status   (step_status)
  );

  assign in_ch.ready = (state_r == S_COLLECT);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;
  assign at_last     = (idx_r == IDX_W'(OUT_COUNT - 1));

  // Read the first entry on entry, then the next one on each transfer
  assign rd_en   = (state_r == S_READ) || ((state_r == S_SEND) && out_ch.ready && !at_last);
  assign rd_addr = (state_r == S_READ) ? idx_r : IDX_W'(idx_r + 1'b1);

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_xfer && step_wr.en) begin
      payload_mem_r[step_wr.addr] <= step_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= payload_mem_r[rd_addr];
    end
  end

  // Sequence collection and sending
  always_comb begin
    state_nxt  = state_r;
    dec_nxt    = dec_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      S_COLLECT: begin
        if (in_xfer) begin
          dec_nxt = step_nxt;
          if (in_ch.is_last) begin
            status_nxt = step_status;
            idx_nxt    = '0;
            state_nxt  = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_xfer) begin
          if (at_last) begin
            dec_nxt   = '0;
            state_nxt = S_COLLECT;
          end else begin
            idx_nxt = IDX_W'(idx_r + 1'b1);
          end
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_COLLECT;
      dec_r    <= '0;
      status_r <= ST_OK;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      dec_r    <= dec_nxt;
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Drive the result: zero past the committed length or on any error
  assign in_len              = (SUM_W'(idx_r) < SUM_W'(dec_r.committed));
  assign out_ch.valid        = (state_r == S_SEND);
  assign out_ch.payload_byte = ((status_r == ST_OK) && in_len) ? rd_data_r : 8'h00;
  assign out_ch.byte_index   = 4'(idx_r);
  assign out_ch.status       = status_r;
  assign out_ch.last_out     = at_last;

  `ASSERT_IMPL(a_no_overlap, clk, rst_n, in_ch.ready, !out_ch.valid)
  `ASSERT_NEXT(a_end_reopens, clk, rst_n, out_xfer && out_ch.last_out, in_ch.ready)
  `ASSERT_IMPL(a_err_zero, clk, rst_n, out_ch.valid && (out_ch.status != ST_OK), out_ch.payload_byte == 8'h00)
  `ASSERT_NEXT(a_last_starts, clk, rst_n, in_xfer && in_ch.is_last, (state_r == S_READ) && (idx_r == '0))

endmodule
`default_nettype wire
